[rtl/avr_pkg.sv]
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants for the axisymmetric velocity revolve
// Beat layouts of both channels, request codes and the angle table used by
// the CORDIC stages.
// ----------------------------------------------------------------------------
package avr_pkg;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } avr_req_e;

  typedef struct packed {
    avr_req_e           req_type;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [5:0]         depth_idx;
    logic signed [15:0] u_in;
    logic signed [15:0] v_in;
  } avr_in_t;

  typedef struct packed {
    logic signed [15:0] u_out;
    logic signed [15:0] v_out;
    logic signed [15:0] w_out;
    logic               outside;
  } avr_out_t;

  localparam logic [6:0] WID_RESET = 7'd64;

  localparam int SQRT_STEPS      = 15;
  localparam int CORDIC_STEPS    = 14;
  localparam int STEPS_PER_GROUP = 3;
  localparam int FRONT_GROUPS    = 5;
  localparam int DIV_BITS        = 16;
  localparam int DIV_PER_GROUP   = 4;
  localparam int DIV_GROUPS      = 4;

  // atan(2^-i) / pi in Q0.16
  function automatic logic [14:0] atan_pi(input int i);
    logic [14:0] v;
    unique case (i)
      0:       v = 15'd16384;
      1:       v = 15'd9672;
      2:       v = 15'd5110;
      3:       v = 15'd2594;
      4:       v = 15'd1302;
      5:       v = 15'd652;
      6:       v = 15'd326;
      7:       v = 15'd163;
      8:       v = 15'd81;
      9:       v = 15'd41;
      10:      v = 15'd20;
      11:      v = 15'd10;
      12:      v = 15'd5;
      13:      v = 15'd3;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/axisymmetric_velocity_revolve.sv]
// ----------------------------------------------------------------------------
// axisymmetric_velocity_revolve: 3D velocity from a revolved 2D plane
// Holds a plane of Q8.8 (u, v) samples and answers voxel queries by
// revolving the plane about its middle column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
//   request. A write beat stores (u_in, v_in) at (row, col) and returns
//   nothing. A query beat names a voxel (row, col, depth_idx) and returns one
//   output beat (u_out, v_out, w_out, outside).
//   cfg_we_i / cfg_data_i load width_in_use; write it only while idle.
// Pipeline:
//   The pipeline is 17 register stages deep (square root and CORDIC share five
//   stages, a two-port banked plane read, blend multipliers, and a 16-bit
//   restoring divider over four stages) and takes one beat every cycle while
//   out_ready_i is high.
// Reset: all stage valids clear and width_in_use returns to 64. The plane
//   contents stay unknown until written.
// Stall: when out_ready_i is low the output beat holds; upstream stages keep
//   filling any empty slot, so input is taken until every stage is full.
// ----------------------------------------------------------------------------
module axisymmetric_velocity_revolve
  import avr_pkg::*;
#(
  parameter int HEIGHT = 64,
  parameter int WIDTH  = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  avr_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output avr_out_t   out_data_o
);

  // Plane is split into even and odd column banks so that a column pair
  // (c, c+1) always hits one entry of each bank.
  localparam int BANK_COLS  = (WIDTH + 1) / 2;
  localparam int BANK_DEPTH = HEIGHT * BANK_COLS;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Stage map
  localparam int ST_D = FRONT_GROUPS + 1;
  localparam int ST_E = ST_D + 1;
  localparam int ST_F = ST_E + 1;
  localparam int ST_G = ST_F + 1;
  localparam int ST_H = ST_G + 1;
  localparam int ST_I = ST_H + 1;
  localparam int ST_O = ST_I + DIV_GROUPS + 1;
  localparam int NST  = ST_O + 1;

  // Front stages: geometry, square root and CORDIC state
  typedef struct packed {
    avr_req_e           req;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [31:0]        uv;
    logic [5:0]         mid;
    logic signed [7:0]  dx;
    logic signed [7:0]  dz;
    logic               outside;
    logic               s_zero;
    logic               dz_zero;
    logic [29:0]        sq_x;
    logic [29:0]        sq_r;
    logic signed [26:0] cx;
    logic signed [26:0] cy;
    logic signed [18:0] cz;
  } front_t;

  // Positions and angle fraction, ready to address the plane
  typedef struct packed {
    avr_req_e          req;
    logic [5:0]        row;
    logic [5:0]        col;
    logic [31:0]       uv;
    logic signed [7:0] dx;
    logic signed [7:0] dz;
    logic              outside;
    logic              s_zero;
    logic [14:0]       r8;
    logic [16:0]       t;
    logic [7:0]        c1;
    logic [7:0]        g1;
    logic [7:0]        c2;
    logic [7:0]        g2;
  } pos_t;

  // Control beside the plane read data
  typedef struct packed {
    avr_req_e          req;
    logic signed [7:0] dx;
    logic signed [7:0] dz;
    logic              outside;
    logic              s_zero;
    logic [14:0]       r8;
    logic [16:0]       t;
    logic [7:0]        g1;
    logic [7:0]        g2;
    logic              z1lo;
    logic              z1hi;
    logic              z2lo;
    logic              z2hi;
    logic              odd1;
    logic              odd2;
  } rd_t;

  typedef struct packed {
    avr_req_e           req;
    logic signed [7:0]  dx;
    logic signed [7:0]  dz;
    logic               outside;
    logic               s_zero;
    logic [14:0]        r8;
    logic [16:0]        t;
    logic signed [25:0] u1;
    logic signed [25:0] v1;
    logic signed [25:0] u2;
    logic signed [25:0] v2;
  } blend_t;

  typedef struct packed {
    avr_req_e           req;
    logic signed [7:0]  dx;
    logic signed [7:0]  dz;
    logic               outside;
    logic               s_zero;
    logic [14:0]        r8;
    logic signed [41:0] vn;
    logic signed [41:0] pu;
  } mix_t;

  typedef struct packed {
    avr_req_e           req;
    logic               outside;
    logic               s_zero;
    logic [14:0]        r8;
    logic signed [49:0] nu;
    logic signed [49:0] nw;
    logic [15:0]        vq;
    logic [15:0]        u0;
  } proj_t;

  typedef struct packed {
    avr_req_e    req;
    logic        outside;
    logic        s_zero;
    logic [14:0] r8;
    logic [30:0] rem_u;
    logic [15:0] q_u;
    logic        neg_u;
    logic [30:0] rem_w;
    logic [15:0] q_w;
    logic        neg_w;
    logic [15:0] vq;
    logic [15:0] u0;
  } div_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Three square-root digits and up to three CORDIC rotations.
  function automatic front_t front_step(input front_t f, input int grp);
    front_t             o;
    int                 j;
    int                 it;
    logic [29:0]        bit_v;
    logic [29:0]        sum;
    logic signed [26:0] xs;
    logic signed [26:0] ys;
    o = f;
    for (j = 0; j < STEPS_PER_GROUP; j++) begin
      it = grp * STEPS_PER_GROUP + j;
      if (it < SQRT_STEPS) begin
        bit_v = 30'd1 << (2 * (SQRT_STEPS - 1 - it));
        sum   = o.sq_r + bit_v;
        if (o.sq_x >= sum) begin
          o.sq_x = o.sq_x - sum;
          o.sq_r = (o.sq_r >> 1) + bit_v;
        end else begin
          o.sq_r = o.sq_r >> 1;
        end
      end
      if (it < CORDIC_STEPS) begin
        xs = o.cx >>> it;
        ys = o.cy >>> it;
        if (!o.cy[26]) begin
          o.cx = o.cx + ys;
          o.cy = o.cy - xs;
          o.cz = o.cz + $signed(19'(atan_pi(it)));
        end else begin
          o.cx = o.cx - ys;
          o.cy = o.cy + xs;
          o.cz = o.cz - $signed(19'(atan_pi(it)));
        end
      end
    end
    return o;
  endfunction

  // Four restoring quotient bits for both projections.
  function automatic div_t div_step(input div_t d, input int grp);
    div_t        o;
    int          j;
    int          k;
    logic [30:0] dsh;
    o = d;
    for (j = 0; j < DIV_PER_GROUP; j++) begin
      k   = DIV_BITS - 1 - (grp * DIV_PER_GROUP + j);
      dsh = 31'(o.r8) << k;
      if (o.rem_u >= dsh) begin
        o.rem_u  = o.rem_u - dsh;
        o.q_u[k] = 1'b1;
      end
      if (o.rem_w >= dsh) begin
        o.rem_w  = o.rem_w - dsh;
        o.q_w[k] = 1'b1;
      end
    end
    return o;
  endfunction

  // Apply sign to a magnitude and clamp to the 16-bit range.
  function automatic logic [15:0] sat_mag(input logic [17:0] q, input logic neg);
    logic [15:0] m;
    m = q[15:0];
    if (q >= 18'd32768) begin
      return neg ? 16'h8000 : 16'h7FFF;
    end
    return neg ? (~m + 16'd1) : m;
  endfunction

  // Divide by 2^24, round half away from zero, saturate.
  function automatic logic [15:0] round_sat24(input logic signed [41:0] x);
    logic [41:0] mag;
    logic [41:0] sum;
    mag = x[41] ? 42'(-x) : 42'(x);
    sum = mag + 42'd8388608;
    return sat_mag(sum[41:24], x[41]);
  endfunction

  function automatic logic signed [25:0] blend(input logic [7:0] g,
                                               input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [9:0]  wa;
    logic signed [9:0]  wb;
    logic signed [25:0] pa;
    logic signed [25:0] pb;
    wa = $signed(10'(9'd256 - 9'(g)));
    wb = $signed({2'b00, g});
    pa = wa * a;
    pb = wb * b;
    return pa + pb;
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic [5:0] row, input logic [7:0] idx);
    return AW'(int'(row) * BANK_COLS + int'(idx));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [6:0] wid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= WID_RESET;
    end else if (cfg_we_i) begin
      wid_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and advance chain: a stage advances when it is empty or the
  // stage after it advances, so bubbles collapse behind a stalled output.
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;

  front_t   f_q [FRONT_GROUPS+1];
  pos_t     d_q;
  rd_t      e_q;
  blend_t   bl_q;
  mix_t     g_q;
  proj_t    h_q;
  div_t     dv_q [DIV_GROUPS+1];
  avr_out_t o_q;

  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[ST_O];
  assign out_data_o  = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < ST_O; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      // Drop write beats here: they leave no result.
      if (en[ST_O]) begin
        vld_q[ST_O] <= vld_q[ST_O-1] && (dv_q[DIV_GROUPS].req == REQ_QUERY);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: offsets from the middle column, squared radius, outside test,
  // square root and CORDIC seeds
  // --------------------------------------------------------------------------
  front_t             f_init;
  logic [5:0]         mid;
  logic [5:0]         mid_m1;
  logic signed [7:0]  dx;
  logic signed [7:0]  dz;
  logic signed [15:0] dx_w;
  logic signed [15:0] dz_w;
  logic [15:0]        dx2;
  logic [15:0]        dz2;
  logic [13:0]        s;
  logic [11:0]        msq;
  logic [6:0]         adz;
  logic [6:0]         ndx;

  always_comb begin
    mid    = wid_q[6:1];
    mid_m1 = mid - 6'd1;
    dx     = $signed({2'b00, in_data_i.col}) - $signed({2'b00, mid});
    dz     = $signed({2'b00, in_data_i.depth_idx}) - $signed({2'b00, mid});
    dx_w   = 16'(dx);
    dz_w   = 16'(dz);
    dx2    = 16'(dx_w * dx_w);
    dz2    = 16'(dz_w * dz_w);
    s      = 14'(dx2 + dz2);
    msq    = 12'({6'd0, mid_m1} * {6'd0, mid_m1});
    adz    = dz[7] ? 7'(-dz) : dz[6:0];
    ndx    = 7'(-dx);

    f_init.req     = in_data_i.req_type;
    f_init.row     = in_data_i.row;
    f_init.col     = in_data_i.col;
    f_init.uv      = {in_data_i.u_in, in_data_i.v_in};
    f_init.mid     = mid;
    f_init.dx      = dx;
    f_init.dz      = dz;
    f_init.outside = (mid == 6'd0) || (s > 14'(msq));
    f_init.s_zero  = (s == 14'd0);
    f_init.dz_zero = (dz == 8'sd0);
    f_init.sq_x    = {s, 16'd0};
    f_init.sq_r    = '0;
    // Rotate by a quarter turn first when the vector points left.
    if (dx[7]) begin
      f_init.cx = $signed(27'({adz, 16'd0}));
      f_init.cy = $signed(27'({ndx, 16'd0}));
      f_init.cz = 19'sd32768;
    end else begin
      f_init.cx = $signed(27'({dx[6:0], 16'd0}));
      f_init.cy = $signed(27'({adz, 16'd0}));
      f_init.cz = 19'sd0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: mirrored positions and clamped angle fraction
  // --------------------------------------------------------------------------
  pos_t        d_d;
  front_t      fl;
  logic [14:0] r8;
  logic [15:0] p1;
  logic [15:0] p2;

  always_comb begin
    fl = f_q[FRONT_GROUPS];
    r8 = fl.sq_r[14:0];
    p1 = 16'({fl.mid, 8'd0}) + 16'(r8);
    p2 = 16'({fl.mid, 8'd0}) - 16'(r8);

    d_d.req     = fl.req;
    d_d.row     = fl.row;
    d_d.col     = fl.col;
    d_d.uv      = fl.uv;
    d_d.dx      = fl.dx;
    d_d.dz      = fl.dz;
    d_d.outside = fl.outside;
    d_d.s_zero  = fl.s_zero;
    d_d.r8      = r8;
    d_d.c1      = p1[15:8];
    d_d.g1      = p1[7:0];
    d_d.c2      = p2[15:8];
    d_d.g2      = p2[7:0];
    priority if (fl.s_zero) begin
      d_d.t = 17'd0;
    end else if (fl.dz_zero) begin
      d_d.t = fl.dx[7] ? 17'd65536 : 17'd0;
    end else if (fl.cz[18]) begin
      d_d.t = 17'd0;
    end else if (fl.cz > 19'sd65536) begin
      d_d.t = 17'd65536;
    end else begin
      d_d.t = 17'(fl.cz);
    end
  end

  // --------------------------------------------------------------------------
  // Stage D -> E: plane banks. Writes retire here too, in beat order with
  // the query reads.
  // --------------------------------------------------------------------------
  logic [31:0]   mem_even [BANK_DEPTH];
  logic [31:0]   mem_odd  [BANK_DEPTH];
  logic [31:0]   rd_even1_q;
  logic [31:0]   rd_even2_q;
  logic [31:0]   rd_odd1_q;
  logic [31:0]   rd_odd2_q;
  logic [AW-1:0] ra_even1;
  logic [AW-1:0] ra_even2;
  logic [AW-1:0] ra_odd1;
  logic [AW-1:0] ra_odd2;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          row_ok;
  logic [8:0]    c1_hi;
  logic [8:0]    c2_hi;
  rd_t           e_d;

  always_comb begin
    c1_hi    = 9'(d_q.c1) + 9'd1;
    c2_hi    = 9'(d_q.c2) + 9'd1;
    // Even column of the pair sits at (c + c[0]) / 2, odd one at c / 2.
    ra_even1 = bank_addr(d_q.row, c1_hi[8:1] & {7'h7F, d_q.c1[0]} | (d_q.c1 >> 1));
    ra_even2 = bank_addr(d_q.row, c2_hi[8:1] & {7'h7F, d_q.c2[0]} | (d_q.c2 >> 1));
    ra_odd1  = bank_addr(d_q.row, d_q.c1 >> 1);
    ra_odd2  = bank_addr(d_q.row, d_q.c2 >> 1);
    if (!d_q.c1[0]) begin
      ra_even1 = bank_addr(d_q.row, d_q.c1 >> 1);
    end else begin
      ra_even1 = bank_addr(d_q.row, c1_hi[8:1]);
    end
    if (!d_q.c2[0]) begin
      ra_even2 = bank_addr(d_q.row, d_q.c2 >> 1);
    end else begin
      ra_even2 = bank_addr(d_q.row, c2_hi[8:1]);
    end

    wr_addr = bank_addr(d_q.row, {3'd0, d_q.col[5:1]});
    wr_en   = vld_q[ST_D] && en[ST_E] && (d_q.req == REQ_WRITE)
              && (int'(d_q.row) < HEIGHT) && (int'(d_q.col) < WIDTH);

    // Columns past the end and rows past the plane read as zero.
    row_ok = int'(d_q.row) < HEIGHT;

    e_d.req     = d_q.req;
    e_d.dx      = d_q.dx;
    e_d.dz      = d_q.dz;
    e_d.outside = d_q.outside;
    e_d.s_zero  = d_q.s_zero;
    e_d.r8      = d_q.r8;
    e_d.t       = d_q.t;
    e_d.g1      = d_q.g1;
    e_d.g2      = d_q.g2;
    e_d.odd1    = d_q.c1[0];
    e_d.odd2    = d_q.c2[0];
    e_d.z1lo    = !(row_ok && int'(d_q.c1) < WIDTH && 9'(d_q.c1) < 9'(wid_q));
    e_d.z1hi    = !(row_ok && int'(c1_hi) < WIDTH && c1_hi < 9'(wid_q));
    e_d.z2lo    = !(row_ok && int'(d_q.c2) < WIDTH && 9'(d_q.c2) < 9'(wid_q));
    e_d.z2hi    = !(row_ok && int'(c2_hi) < WIDTH && c2_hi < 9'(wid_q));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !d_q.col[0]) begin
      mem_even[wr_addr] <= d_q.uv;
    end
    if (en[ST_E]) begin
      rd_even1_q <= mem_even[ra_even1];
      rd_even2_q <= mem_even[ra_even2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && d_q.col[0]) begin
      mem_odd[wr_addr] <= d_q.uv;
    end
    if (en[ST_E]) begin
      rd_odd1_q <= mem_odd[ra_odd1];
      rd_odd2_q <= mem_odd[ra_odd2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: linear interpolation along each mirrored column pair
  // --------------------------------------------------------------------------
  blend_t      bl_d;
  logic [31:0] s1lo;
  logic [31:0] s1hi;
  logic [31:0] s2lo;
  logic [31:0] s2hi;

  always_comb begin
    s1lo = e_q.z1lo ? 32'd0 : (e_q.odd1 ? rd_odd1_q : rd_even1_q);
    s1hi = e_q.z1hi ? 32'd0 : (e_q.odd1 ? rd_even1_q : rd_odd1_q);
    s2lo = e_q.z2lo ? 32'd0 : (e_q.odd2 ? rd_odd2_q : rd_even2_q);
    s2hi = e_q.z2hi ? 32'd0 : (e_q.odd2 ? rd_even2_q : rd_odd2_q);

    bl_d.req     = e_q.req;
    bl_d.dx      = e_q.dx;
    bl_d.dz      = e_q.dz;
    bl_d.outside = e_q.outside;
    bl_d.s_zero  = e_q.s_zero;
    bl_d.r8      = e_q.r8;
    bl_d.t       = e_q.t;
    bl_d.u1      = blend(e_q.g1, $signed(s1lo[31:16]), $signed(s1hi[31:16]));
    bl_d.v1      = blend(e_q.g1, $signed(s1lo[15:0]), $signed(s1hi[15:0]));
    bl_d.u2      = blend(e_q.g2, $signed(s2lo[31:16]), $signed(s2hi[31:16]));
    bl_d.v2      = blend(e_q.g2, $signed(s2lo[15:0]), $signed(s2hi[15:0]));
  end

  // --------------------------------------------------------------------------
  // Stage G: angular weighting of the two sides
  // --------------------------------------------------------------------------
  mix_t              g_d;
  logic [16:0]       ip;
  logic signed [17:0] sip;
  logic signed [17:0] st;

  always_comb begin
    ip  = 17'd65536 - bl_q.t;
    sip = $signed({1'b0, ip});
    st  = $signed({1'b0, bl_q.t});

    g_d.req     = bl_q.req;
    g_d.dx      = bl_q.dx;
    g_d.dz      = bl_q.dz;
    g_d.outside = bl_q.outside;
    g_d.s_zero  = bl_q.s_zero;
    g_d.r8      = bl_q.r8;
    g_d.vn      = bl_q.v1 * sip + bl_q.v2 * st;
    g_d.pu      = bl_q.u1 * sip - bl_q.u2 * st;
  end

  // --------------------------------------------------------------------------
  // Stage H: project radial velocity onto x and z, round the axial one
  // --------------------------------------------------------------------------
  proj_t h_d;

  always_comb begin
    h_d.req     = g_q.req;
    h_d.outside = g_q.outside;
    h_d.s_zero  = g_q.s_zero;
    h_d.r8      = g_q.r8;
    h_d.nu      = g_q.pu * g_q.dx;
    h_d.nw      = g_q.pu * g_q.dz;
    h_d.vq      = round_sat24(g_q.vn);
    h_d.u0      = round_sat24(g_q.pu);
  end

  // --------------------------------------------------------------------------
  // Stage I: divider seed. round(|N| * 2^8 / (r8 * 2^24)) reduces to
  // floor((|N| + r8 * 2^15) / 2^16) / r8.
  // --------------------------------------------------------------------------
  div_t        i_d;
  logic [49:0] au;
  logic [49:0] aw;
  logic [49:0] su;
  logic [49:0] sw;

  always_comb begin
    au = h_q.nu[49] ? 50'(-h_q.nu) : 50'(h_q.nu);
    aw = h_q.nw[49] ? 50'(-h_q.nw) : 50'(h_q.nw);
    su = au + (50'(h_q.r8) << 15);
    sw = aw + (50'(h_q.r8) << 15);

    i_d.req     = h_q.req;
    i_d.outside = h_q.outside;
    i_d.s_zero  = h_q.s_zero;
    i_d.r8      = h_q.r8;
    i_d.rem_u   = su[46:16];
    i_d.q_u     = '0;
    i_d.neg_u   = h_q.nu[49];
    i_d.rem_w   = sw[46:16];
    i_d.q_w     = '0;
    i_d.neg_w   = h_q.nw[49];
    i_d.vq      = h_q.vq;
    i_d.u0      = h_q.u0;
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturate, pick the on-axis and outside cases
  // --------------------------------------------------------------------------
  avr_out_t o_d;
  div_t     dl;

  always_comb begin
    dl = dv_q[DIV_GROUPS];
    if (dl.outside) begin
      o_d.u_out = '0;
      o_d.v_out = '0;
      o_d.w_out = '0;
    end else if (dl.s_zero) begin
      o_d.u_out = $signed(dl.u0);
      o_d.v_out = $signed(dl.vq);
      o_d.w_out = '0;
    end else begin
      o_d.u_out = $signed(sat_mag({2'b00, dl.q_u}, dl.neg_u));
      o_d.v_out = $signed(dl.vq);
      o_d.w_out = $signed(sat_mag({2'b00, dl.q_w}, dl.neg_w));
    end
    o_d.outside = dl.outside;
  end

  // --------------------------------------------------------------------------
  // Payload registers: advance with their stage, hold on stall
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f_q[0] <= f_init;
    end
    for (int k = 1; k <= FRONT_GROUPS; k++) begin
      if (en[k]) begin
        f_q[k] <= front_step(f_q[k-1], k - 1);
      end
    end
    if (en[ST_D]) begin
      d_q <= d_d;
    end
    if (en[ST_E]) begin
      e_q <= e_d;
    end
    if (en[ST_F]) begin
      bl_q <= bl_d;
    end
    if (en[ST_G]) begin
      g_q <= g_d;
    end
    if (en[ST_H]) begin
      h_q <= h_d;
    end
    if (en[ST_I]) begin
      dv_q[0] <= i_d;
    end
    for (int g = 0; g < DIV_GROUPS; g++) begin
      if (en[ST_I+1+g]) begin
        dv_q[g+1] <= div_step(dv_q[g], g);
      end
    end
    if (en[ST_O]) begin
      o_q <= o_d;
    end
  end

endmodule
